>>> hdl/slts_pkg.sv
// ----------------------------------------------------------------------------
// slts_pkg : shared types and constants of the lru tag store
// field widths, csr indexes and reset values, configuration and control
// structs and the sequencer state type
// ----------------------------------------------------------------------------
`default_nettype none

package slts_pkg;

   localparam int ADDR_W      = 64;
   localparam int OFFSET_W    = 5;
   localparam int SET_W       = 4;
   localparam int WAYS_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   // widest masked set value: set_bits is at most 15
   localparam int SET_VAL_W   = (2 ** SET_W) - 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [OFFSET_W-1:0] OFFSET_BITS_RESET = 5'd6;
   localparam logic [SET_W-1:0]    SET_BITS_RESET    = 4'd6;
   localparam logic [WAYS_W-1:0]   WAYS_RESET        = 4'd4;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_bits;
      logic [SET_W-1:0]    set_bits;
      logic [WAYS_W-1:0]   ways_in_use;
   } cfg_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUOT,
      ST_READ,
      ST_UPDATE
   } seq_state_type;

endpackage

`default_nettype wire

>>> hdl/slts_req_if.sv
// ----------------------------------------------------------------------------
// slts_req_if : request channel
// valid/ready channel carrying one byte address per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface slts_req_if;
   logic                         valid;
   logic                         ready;
   logic [slts_pkg::ADDR_W-1:0]  address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

>>> hdl/slts_rsp_if.sv
// ----------------------------------------------------------------------------
// slts_rsp_if : response channel
// valid/ready channel carrying the hit flag of one lookup per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface slts_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, output hit, input ready);
   modport sink   (input valid, input hit, output ready);
endinterface

`default_nettype wire

>>> hdl/set_assoc_lru_tag_store.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store : tag store of a set-associative lru cache
// requests are handled one at a time: index reduction, row read, row write
// the response is registered with the row write; both wait while the output is full
// the next request is taken in the cycle the previous row is written back
// reset: synchronous; a clearing pass over every set follows, req ready low
// csr writes are taken at any time, including during the clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_tag_store #(
   parameter int MAX_SETS  = 1024,
   parameter int MAX_WAYS  = 8,
   parameter int TAG_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   slts_req_if.sink                                  req_bus,
   slts_rsp_if.source                                rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [slts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [slts_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDXW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int AW   = $clog2(MAX_WAYS + 1);

   // configuration registers
   slts_pkg::cfg_type cfg_ff;
   slts_pkg::cfg_type cfg_in;

   // sequencer
   slts_pkg::seq_state_type state_ff;
   slts_pkg::seq_state_type state_in;

   logic                    req_ready;
   logic                    req_acc;
   logic                    out_free;
   logic                    rsp_load;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_hit_ff;
   logic                    rsp_hit_in;
   slts_pkg::store_ctl_type store_ctl;

   // datapath between the parts
   logic [IDXW-1:0]                    set_index;
   logic [IDXW-1:0]                    set_index_ff;
   logic [TAG_WIDTH-1:0]               tag;
   logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] rd_tag;
   logic [MAX_WAYS-1:0]                rd_valid;
   logic [MAX_WAYS-1:0][AW-1:0]        rd_age;
   logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] wr_tag;
   logic [MAX_WAYS-1:0]                wr_valid;
   logic [MAX_WAYS-1:0][AW-1:0]        wr_age;
   logic                               lookup_hit;
   logic                               clear_busy;

   // csr writes, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            slts_pkg::CSR_OFFSET_BITS: cfg_in.offset_bits = csr_wdata[4:0];
            slts_pkg::CSR_SET_BITS:    cfg_in.set_bits    = csr_wdata[3:0];
            slts_pkg::CSR_WAYS_IN_USE: cfg_in.ways_in_use = csr_wdata[3:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits <= slts_pkg::OFFSET_BITS_RESET;
         cfg_ff.set_bits    <= slts_pkg::SET_BITS_RESET;
         cfg_ff.ways_in_use <= slts_pkg::WAYS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_acc  = req_bus.valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slts_pkg::ST_CLEAR: begin
            if (!clear_busy) state_in = slts_pkg::ST_IDLE;
         end
         slts_pkg::ST_IDLE: begin
            if (req_acc) state_in = slts_pkg::ST_QUOT;
         end
         slts_pkg::ST_QUOT: begin
            state_in = slts_pkg::ST_READ;
         end
         slts_pkg::ST_READ: begin
            state_in = slts_pkg::ST_UPDATE;
         end
         slts_pkg::ST_UPDATE: begin
            if (out_free) state_in = req_acc ? slts_pkg::ST_QUOT : slts_pkg::ST_IDLE;
         end
         default: state_in = slts_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready       = 1'b0;
      rsp_load        = 1'b0;
      store_ctl.rd_en = 1'b0;
      store_ctl.wr_en = 1'b0;
      case (state_ff)
         slts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         slts_pkg::ST_READ: begin
            store_ctl.rd_en = 1'b1;
         end
         slts_pkg::ST_UPDATE: begin
            // write back once, in the cycle the result goes to the output register
            req_ready       = out_free;
            rsp_load        = out_free;
            store_ctl.wr_en = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slts_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // set index held for the write back
   always_ff @(posedge clock) begin
      if (store_ctl.rd_en) begin
         set_index_ff <= set_index;
      end
   end

   // response output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = lookup_hit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff <= rsp_hit_in;
   end

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.hit   = rsp_hit_ff;

   // address split and set reduction
   slts_set_index #(
      .MAX_SETS  (MAX_SETS),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_set_index (
      .clock     (clock),
      .cfg       (cfg_ff),
      .address   (req_bus.address),
      .load      (req_acc),
      .set_index (set_index),
      .tag       (tag)
   );

   // tag and state rows
   slts_line_store #(
      .MAX_SETS  (MAX_SETS),
      .MAX_WAYS  (MAX_WAYS),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .rd_addr    (set_index),
      .wr_addr    (set_index_ff),
      .wr_tag     (wr_tag),
      .wr_valid   (wr_valid),
      .wr_age     (wr_age),
      .rd_tag     (rd_tag),
      .rd_valid   (rd_valid),
      .rd_age     (rd_age),
      .clear_busy (clear_busy)
   );

   // compare, victim choice and ageing
   slts_lru_update #(
      .MAX_WAYS  (MAX_WAYS),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_lru_update (
      .cfg      (cfg_ff),
      .tag      (tag),
      .rd_tag   (rd_tag),
      .rd_valid (rd_valid),
      .rd_age   (rd_age),
      .hit      (lookup_hit),
      .wr_tag   (wr_tag),
      .wr_valid (wr_valid),
      .wr_age   (wr_age)
   );

   // no request beat while the clearing pass runs
   assert_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_bus.ready)
      else $error("request taken during clearing pass");

   // a row is written back only from the update step
   assert_wr_in_update: assert property (@(posedge clock) disable iff (reset)
      store_ctl.wr_en |-> (state_ff == slts_pkg::ST_UPDATE))
      else $error("row write outside update step");

   // a new result never overwrites one still waiting
   assert_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> rsp_bus.ready)
      else $error("pending response overwritten");

   // an accepted request always goes on to the quotient step
   assert_accept_to_quot: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == slts_pkg::ST_QUOT))
      else $error("accepted request not processed");

   // the row read follows the request beat, after the quotient step
   assert_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##2 store_ctl.rd_en)
      else $error("row read not issued after request");

endmodule

`default_nettype wire

>>> hdl/slts_set_index.sv
// ----------------------------------------------------------------------------
// slts_set_index : address split and set index reduction
// splits the address into masked set value and tag, then reduces the set
// value modulo the store depth by reciprocal multiply with one correction
// ----------------------------------------------------------------------------
`default_nettype none

module slts_set_index #(
   parameter int MAX_SETS  = 1024,
   parameter int TAG_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire slts_pkg::cfg_type           cfg,
   input  wire logic [slts_pkg::ADDR_W-1:0] address,
   input  wire logic                        load,
   output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] set_index,
   output logic [TAG_WIDTH-1:0]             tag
);

   localparam int IDXW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int VW      = slts_pkg::SET_VAL_W;
   localparam int RECIP_W = VW + 1;
   localparam int PROD_W  = VW + RECIP_W;
   localparam int MOD_W   = $clog2(MAX_SETS + 1);
   localparam int MUL_W   = VW + MOD_W;
   localparam int SHIFT_W = slts_pkg::OFFSET_W + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((32'd1 << VW) / MAX_SETS);

   logic [slts_pkg::ADDR_W-1:0] shifted;
   logic [slts_pkg::ADDR_W-1:0] tag_shifted;
   logic [SHIFT_W-1:0]          tag_shift;
   logic [VW:0]                 mask_full;
   logic [VW-1:0]               set_val_in;
   logic [VW-1:0]               set_val_ff;
   logic [TAG_WIDTH-1:0]        tag_in;
   logic [TAG_WIDTH-1:0]        tag_ff;
   logic [PROD_W-1:0]           prod;
   logic [VW-1:0]               quot_in;
   logic [VW-1:0]               quot_ff;
   logic [MUL_W-1:0]            quot_mul;
   logic [MUL_W-1:0]            rem_raw;
   logic [MUL_W-1:0]            rem_fix;

   always_comb begin
      shifted     = address >> cfg.offset_bits;
      mask_full   = ((VW + 1)'(1) << cfg.set_bits) - (VW + 1)'(1);
      set_val_in  = shifted[VW-1:0] & mask_full[VW-1:0];
      tag_shift   = SHIFT_W'(cfg.offset_bits) + SHIFT_W'(cfg.set_bits);
      tag_shifted = address >> tag_shift;
      tag_in      = tag_shifted[TAG_WIDTH-1:0];
   end

   // quotient estimate, at most one below the true quotient
   always_comb begin
      prod    = PROD_W'(set_val_ff) * PROD_W'(RECIP);
      quot_in = prod[VW +: VW];
   end

   always_comb begin
      quot_mul = MUL_W'(quot_ff) * MUL_W'(MAX_SETS);
      rem_raw  = MUL_W'(set_val_ff) - quot_mul;
      rem_fix  = (rem_raw >= MUL_W'(MAX_SETS)) ? rem_raw - MUL_W'(MAX_SETS) : rem_raw;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         set_val_ff <= set_val_in;
         tag_ff     <= tag_in;
      end
      quot_ff <= quot_in;
   end

   assign set_index = rem_fix[IDXW-1:0];
   assign tag       = tag_ff;

endmodule

`default_nettype wire

>>> hdl/slts_line_store.sv
// ----------------------------------------------------------------------------
// slts_line_store : tag and line state memories
// one row per set, registered read, single write port, and a clearing pass
// over the state memory after reset
// ----------------------------------------------------------------------------
`default_nettype none

module slts_line_store #(
   parameter int MAX_SETS  = 1024,
   parameter int MAX_WAYS  = 8,
   parameter int TAG_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire slts_pkg::store_ctl_type               ctl,
   input  wire logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] rd_addr,
   input  wire logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] wr_addr,
   input  wire logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]    wr_tag,
   input  wire logic [MAX_WAYS-1:0]                   wr_valid,
   input  wire logic [MAX_WAYS-1:0][$clog2(MAX_WAYS + 1)-1:0] wr_age,
   output logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]         rd_tag,
   output logic [MAX_WAYS-1:0]                        rd_valid,
   output logic [MAX_WAYS-1:0][$clog2(MAX_WAYS + 1)-1:0] rd_age,
   output logic                                       clear_busy
);

   localparam int IDXW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int AW   = $clog2(MAX_WAYS + 1);

   logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] tag_mem [MAX_SETS];
   // per way: valid in the top bit, age below
   logic [MAX_WAYS-1:0][AW:0]          state_mem [MAX_SETS];

   logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] rd_tag_ff;
   logic [MAX_WAYS-1:0][AW:0]          rd_state_ff;
   logic [MAX_WAYS-1:0][AW:0]          wr_state;
   logic                               clear_busy_ff;
   logic                               clear_busy_in;
   logic [IDXW-1:0]                    clear_idx_ff;
   logic [IDXW-1:0]                    clear_idx_in;

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         wr_state[i] = {wr_valid[i], wr_age[i]};
         rd_valid[i] = rd_state_ff[i][AW];
         rd_age[i]   = rd_state_ff[i][AW-1:0];
      end
   end

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_idx_in  = clear_idx_ff;
      if (clear_busy_ff) begin
         clear_idx_in = clear_idx_ff + 1'b1;
         if (clear_idx_ff == IDXW'(MAX_SETS - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_idx_ff  <= clear_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         state_mem[clear_idx_ff] <= '0;
      end else if (ctl.wr_en) begin
         state_mem[wr_addr] <= wr_state;
      end
      if (ctl.wr_en) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (ctl.rd_en) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_state_ff <= state_mem[rd_addr];
      end
   end

   assign rd_tag     = rd_tag_ff;
   assign clear_busy = clear_busy_ff;

endmodule

`default_nettype wire

>>> hdl/slts_lru_update.sv
// ----------------------------------------------------------------------------
// slts_lru_update : tag compare and replacement
// compares the tag with the in-use ways of the row read, picks the touched
// way and builds the row written back with updated ages
// ----------------------------------------------------------------------------
`default_nettype none

module slts_lru_update #(
   parameter int MAX_WAYS  = 8,
   parameter int TAG_WIDTH = 32
) (
   input  wire slts_pkg::cfg_type                  cfg,
   input  wire logic [TAG_WIDTH-1:0]               tag,
   input  wire logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] rd_tag,
   input  wire logic [MAX_WAYS-1:0]                rd_valid,
   input  wire logic [MAX_WAYS-1:0][$clog2(MAX_WAYS + 1)-1:0] rd_age,
   output logic                                    hit,
   output logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]      wr_tag,
   output logic [MAX_WAYS-1:0]                     wr_valid,
   output logic [MAX_WAYS-1:0][$clog2(MAX_WAYS + 1)-1:0] wr_age
);

   localparam int AW = $clog2(MAX_WAYS + 1);
   localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   logic [AW-1:0]       active;
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic                hit_found;
   logic [WW-1:0]       hit_way;
   logic                inv_found;
   logic [WW-1:0]       inv_way;
   logic [WW-1:0]       lru_way;
   logic [AW-1:0]       best_age;
   logic [WW-1:0]       touched;

   // zero ways means one, too many means all
   always_comb begin
      if (cfg.ways_in_use == '0) begin
         active = AW'(1);
      end else if ({1'b0, cfg.ways_in_use} > 5'(MAX_WAYS)) begin
         active = AW'(MAX_WAYS);
      end else begin
         active = AW'(cfg.ways_in_use);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i] = (i < int'(active));
         match[i]  = in_use[i] && rd_valid[i] && (rd_tag[i] == tag);
      end
   end

   // lowest matching way, lowest invalid way
   always_comb begin
      hit_found = 1'b0;
      hit_way   = '0;
      inv_found = 1'b0;
      inv_way   = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_found = 1'b1;
            hit_way   = WW'(i);
         end
         if (in_use[i] && !rd_valid[i]) begin
            inv_found = 1'b1;
            inv_way   = WW'(i);
         end
      end
   end

   // oldest way, lowest on a tie
   always_comb begin
      lru_way  = '0;
      best_age = rd_age[0];
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (rd_age[i] > best_age)) begin
            best_age = rd_age[i];
            lru_way  = WW'(i);
         end
      end
   end

   always_comb begin
      if (hit_found) begin
         touched = hit_way;
      end else if (inv_found) begin
         touched = inv_way;
      end else begin
         touched = lru_way;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         wr_valid[i] = rd_valid[i];
         wr_tag[i]   = rd_tag[i];
         wr_age[i]   = rd_age[i];
         if (in_use[i] && (rd_age[i] < active)) begin
            wr_age[i] = rd_age[i] + 1'b1;
         end
         if (WW'(i) == touched) begin
            wr_age[i] = '0;
            if (!hit_found) begin
               wr_valid[i] = 1'b1;
               wr_tag[i]   = tag;
            end
         end
      end
   end

   assign hit = hit_found;

endmodule

`default_nettype wire
